// ===== rtl/rhpa_pkg.sv =====
// Shared types, codes, fixed-point constants and the divider step function.
package rhpa_pkg;

	typedef enum logic [2:0] {
		OP_TO_HLS     = 3'd0,
		OP_FROM_HLS   = 3'd1,
		OP_ROTATE_HUE = 3'd2,
		OP_INC_SAT    = 3'd3,
		OP_DEC_SAT    = 3'd4,
		OP_INC_LUM    = 3'd5,
		OP_DEC_LUM    = 3'd6,
		OP_SPARE      = 3'd7
	} op_t;

	localparam int unsigned LAT_HLS = 6;
	localparam int unsigned LAT_RGB = 7;

	localparam logic [24:0] DEG60  = 25'd3932160;
	localparam logic [24:0] DEG120 = 25'd7864320;
	localparam logic [24:0] DEG180 = 25'd11796480;
	localparam logic [24:0] DEG240 = 25'd15728640;

	localparam logic [19:0] HUE_TWO  = 20'd131072;
	localparam logic [19:0] HUE_FOUR = 20'd262144;
	localparam logic [19:0] HUE_SIX  = 20'd393216;

	localparam logic [15:0] RECIP17 = 16'd61681;
	localparam logic [22:0] RECIP15 = 23'd4473925;

	typedef struct packed {
		logic [8:0] rem;
		logic [5:0] q;
	} div_part_t;

	function automatic div_part_t div_steps(input logic [8:0] rem_in, input logic [8:0] den,
		input logic [5:0] bits);
		div_part_t res;
		logic [8:0] rem;
		logic [9:0] t;
		rem = rem_in;
		res.q = '0;
		for (int i = 5; i >= 0; i--) begin
			t = {rem, bits[i]};
			if (t >= {1'b0, den}) begin
				rem = 9'(t - {1'b0, den});
				res.q[i] = 1'b1;
			end else begin
				rem = t[8:0];
			end
		end
		res.rem = rem;
		return res;
	endfunction

endpackage

// ===== rtl/rhpa_div.sv =====
// Three-stage restoring divider: (num << 16) / den, six quotient bits per stage.
module rhpa_div (
	input  logic        clk,
	input  logic        adv,
	input  logic [7:0]  num,
	input  logic [8:0]  den,
	output logic [17:0] quot
);
	rhpa_pkg::div_part_t pa, pb, pc;
	logic [8:0]  rem_s1, rem_s2;
	logic [8:0]  den_s1, den_s2;
	logic [5:0]  q_s1;
	logic [11:0] q_s2;
	logic [17:0] q_s3;

	assign pa = rhpa_pkg::div_steps({3'b000, num[7:2]}, den, {num[1:0], 4'b0000});
	assign pb = rhpa_pkg::div_steps(rem_s1, den_s1, 6'b000000);
	assign pc = rhpa_pkg::div_steps(rem_s2, den_s2, 6'b000000);

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s1 <= pa.rem;
			den_s1 <= den;
			q_s1   <= pa.q;
			rem_s2 <= pb.rem;
			den_s2 <= den_s1;
			q_s2   <= {q_s1, pb.q};
			q_s3   <= {q_s2, pc.q};
		end
	end

	assign quot = q_s3;
endmodule

// ===== rtl/rhpa_to_hls.sv =====
// RGB to HLS conversion pipeline, six stages.
module rhpa_to_hls (
	input  logic       clk,
	input  logic       adv,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	output logic [7:0] hue,
	output logic [7:0] lum,
	output logic [7:0] sat
);
	typedef enum logic [1:0] {MAX_RED, MAX_GREEN, MAX_BLUE} max_sel_t;
	typedef struct packed {
		logic [7:0] lum;
		max_sel_t   win;
		logic       zero;
	} side_t;

	logic [7:0] mx, mn, diff;
	logic [8:0] sum, den;
	max_sel_t   win;

	logic [7:0] diff_s1, dr_s1, dg_s1, db_s1;
	logic [8:0] den_s1;
	side_t      side_s1, side_s2, side_s3, side_s4;
	logic [17:0] f_q, nr_q, ng_q, nb_q;

	logic [19:0] kx, xw;
	logic [24:0] sat_prod;
	logic [18:0] x_s5;
	logic [7:0]  sat_s5, lum_s5, hue_s6, lum_s6, sat_s6;
	logic        zero_s5;
	logic [25:0] hue_prod;

	always_comb begin
		mx = red;
		mn = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		diff = mx - mn;
		sum  = {1'b0, mx} + {1'b0, mn};
		den  = (sum[8:1] <= 8'd128) ? sum : 9'd510 - sum;
		if (blue == mx) win = MAX_BLUE;
		else if (green == mx) win = MAX_GREEN;
		else win = MAX_RED;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			diff_s1      <= diff;
			den_s1       <= den;
			dr_s1        <= mx - red;
			dg_s1        <= mx - green;
			db_s1        <= mx - blue;
			side_s1.lum  <= sum[8:1];
			side_s1.win  <= win;
			side_s1.zero <= (diff == 8'd0);
			side_s2      <= side_s1;
			side_s3      <= side_s2;
			side_s4      <= side_s3;
		end
	end

	rhpa_div u_div_sat (.clk(clk), .adv(adv), .num(diff_s1), .den(den_s1), .quot(f_q));
	rhpa_div u_div_r (.clk(clk), .adv(adv), .num(dr_s1), .den({1'b0, diff_s1}), .quot(nr_q));
	rhpa_div u_div_g (.clk(clk), .adv(adv), .num(dg_s1), .den({1'b0, diff_s1}), .quot(ng_q));
	rhpa_div u_div_b (.clk(clk), .adv(adv), .num(db_s1), .den({1'b0, diff_s1}), .quot(nb_q));

	always_comb begin
		case (side_s4.win)
			MAX_BLUE:  kx = rhpa_pkg::HUE_FOUR + {2'b00, ng_q} - {2'b00, nr_q};
			MAX_GREEN: kx = rhpa_pkg::HUE_TWO + {2'b00, nr_q} - {2'b00, nb_q};
			default:   kx = rhpa_pkg::HUE_SIX + {2'b00, nb_q} - {2'b00, ng_q};
		endcase
		xw = (kx > rhpa_pkg::HUE_SIX) ? kx - rhpa_pkg::HUE_SIX : kx;
		sat_prod = 25'(f_q[16:0]) * 25'(8'd255);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s5    <= xw[18:0];
			sat_s5  <= side_s4.zero ? 8'd0 : sat_prod[23:16];
			lum_s5  <= side_s4.lum;
			zero_s5 <= side_s4.zero;
			hue_s6  <= zero_s5 ? 8'd0 : hue_prod[24:17];
			lum_s6  <= lum_s5;
			sat_s6  <= sat_s5;
		end
	end

	assign hue_prod = 26'(x_s5) * 26'(7'd85);

	assign hue = hue_s6;
	assign lum = lum_s6;
	assign sat = sat_s6;
endmodule

// ===== rtl/rhpa_to_rgb.sv =====
// HLS to RGB conversion pipeline, seven stages, three channel lanes.
module rhpa_to_rgb (
	input  logic       clk,
	input  logic       adv,
	input  logic [7:0] hue,
	input  logic [7:0] lum,
	input  logic [7:0] sat,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue
);
	typedef enum logic [1:0] {RG_RISE, RG_HIGH, RG_FALL, RG_LOW} region_t;

	logic [8:0]  bypass_s [1:6];
	logic [16:0] fl_s1, fs_s1, n_s1;
	logic [8:0]  q_s1;
	logic [12:0] y;
	logic [28:0] yq;
	logic [33:0] pp;
	logic [17:0] prod_s2;
	logic [16:0] fl_s2, fs_s2;
	logic [24:0] d_s2;

	logic [18:0] m2;
	logic [19:0] m1, md;
	logic [24:0] ang [3];
	logic [24:0] ang_s3 [3];
	logic [19:0] m1_s3, m1_s4, m1_s5;
	logic [18:0] m2_s3, m2_s4, m2_s5;
	logic [17:0] md_s3;

	region_t     region [3];
	region_t     region_s4 [3];
	region_t     region_s5 [3];
	logic [21:0] wt [3];
	logic [39:0] p_s4 [3];
	logic [44:0] qp [3];
	logic [18:0] qq_s5 [3];
	logic signed [20:0] v [3];
	logic signed [20:0] v_s6 [3];
	logic [27:0] vp [3];
	logic [7:0]  ch_s7 [3];

	assign y  = 13'(hue) * 13'd24;
	assign yq = 29'(y) * 29'(rhpa_pkg::RECIP17);
	assign pp = 34'(fl_s1) * 34'(fs_s1);

	always_ff @(posedge clk) begin
		if (adv) begin
			bypass_s[1] <= {(sat == 8'd0), lum};
			for (int i = 2; i <= 6; i++) bypass_s[i] <= bypass_s[i-1];
			fl_s1   <= {1'b0, lum, 8'd0} + {9'd0, lum} + {16'd0, &lum};
			fs_s1   <= {1'b0, sat, 8'd0} + {9'd0, sat} + {16'd0, &sat};
			n_s1    <= 17'(hue) * 17'd360;
			q_s1    <= yq[28:20];
			prod_s2 <= pp[33:16];
			fl_s2   <= fl_s1;
			fs_s2   <= fs_s1;
			d_s2    <= 25'(n_s1) * 25'd257 + 25'(q_s1);
		end
	end

	always_comb begin
		if (fl_s2 <= 17'd32768) m2 = 19'(fl_s2) + 19'(prod_s2);
		else m2 = 19'(fl_s2) + 19'(fs_s2) - 19'(prod_s2);
		m1 = {2'b00, fl_s2, 1'b0} - {1'b0, m2};
		md = {1'b0, m2} - m1;
		ang[0] = (d_s2 > rhpa_pkg::DEG240) ? d_s2 - rhpa_pkg::DEG240 : d_s2 + rhpa_pkg::DEG120;
		ang[1] = d_s2;
		ang[2] = (d_s2 < rhpa_pkg::DEG120) ? d_s2 + rhpa_pkg::DEG240 : d_s2 - rhpa_pkg::DEG120;
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			if (ang_s3[c] < rhpa_pkg::DEG60) begin
				region[c] = RG_RISE;
				wt[c] = ang_s3[c][21:0];
			end else if (ang_s3[c] < rhpa_pkg::DEG180) begin
				region[c] = RG_HIGH;
				wt[c] = '0;
			end else if (ang_s3[c] < rhpa_pkg::DEG240) begin
				region[c] = RG_FALL;
				wt[c] = 22'(rhpa_pkg::DEG240 - ang_s3[c]);
			end else begin
				region[c] = RG_LOW;
				wt[c] = '0;
			end
			qp[c] = 45'(p_s4[c][39:18]) * 45'(rhpa_pkg::RECIP15);
			case (region_s5[c])
				RG_RISE, RG_FALL: v[c] = 21'($signed(m1_s5)) + 21'(qq_s5[c]);
				RG_HIGH:          v[c] = 21'(m2_s5);
				default:          v[c] = 21'($signed(m1_s5));
			endcase
			vp[c] = 28'(v_s6[c][19:0]) * 28'(8'd255);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m1_s3 <= m1;
			m2_s3 <= m2;
			md_s3 <= md[17:0];
			m1_s4 <= m1_s3;
			m2_s4 <= m2_s3;
			m1_s5 <= m1_s4;
			m2_s5 <= m2_s4;
			for (int c = 0; c < 3; c++) begin
				ang_s3[c]    <= ang[c];
				region_s4[c] <= region[c];
				p_s4[c]      <= 40'(md_s3) * 40'(wt[c]);
				region_s5[c] <= region_s4[c];
				qq_s5[c]     <= qp[c][44:26];
				v_s6[c]      <= v[c];
				if (bypass_s[6][8]) ch_s7[c] <= bypass_s[6][7:0];
				else if (v_s6[c][20]) ch_s7[c] <= 8'd0;
				else if (vp[c][27:16] > 12'd255) ch_s7[c] <= 8'd255;
				else ch_s7[c] <= vp[c][23:16];
			end
		end
	end

	assign red   = ch_s7[0];
	assign green = ch_s7[1];
	assign blue  = ch_s7[2];
endmodule

// ===== rtl/rgb_hls_pixel_adjust_top.sv =====
// Top level: RGB/HLS pixel converter and adjuster pipeline.
// An accepted item passes the HLS path, the adjust step, the RGB path and the output register.
// Throughput: one item per cycle; the output stall holds every stage.
// The HLS path uses three-stage dividers; the RGB path uses seven stages.
// Reset clears only the stage valid bits; data registers are not reset.
module rgb_hls_pixel_adjust_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        operation,
	input  logic [7:0]        red,
	input  logic [7:0]        green,
	input  logic [7:0]        blue,
	input  logic [7:0]        hue_in,
	input  logic [7:0]        lum_in,
	input  logic [7:0]        sat_in,
	input  logic signed [7:0] amount,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        red_out,
	output logic [7:0]        green_out,
	output logic [7:0]        blue_out,
	output logic [7:0]        hue_out,
	output logic [7:0]        lum_out,
	output logic [7:0]        sat_out
);
	typedef struct packed {
		logic [2:0] op;
		logic [7:0] amt;
		logic [7:0] r, g, b, h, l, s;
	} ctl_t;

	typedef struct packed {
		logic       pass;
		logic [7:0] r, g, b, h, l, s;
	} res_t;

	logic       adv;
	logic [15:1] vld_s;
	ctl_t       ctl_s [1:6];
	res_t       res_s [7:14];
	res_t       adj;
	logic [7:0] hls_hue, hls_lum, hls_sat, rgb_r, rgb_g, rgb_b;
	logic       out_pass_q;
	logic [7:0] red_q, green_q, blue_q, hue_q, lum_q, sat_q;

	function automatic logic [7:0] clamp_step(input logic [7:0] v, input logic [7:0] a,
		input logic sub);
		logic signed [9:0] t;
		if (sub) t = $signed({2'b00, v}) - $signed({{2{a[7]}}, a});
		else t = $signed({2'b00, v}) + $signed({{2{a[7]}}, a});
		if (t < 0) return 8'd0;
		if (t > 10'sd255) return 8'd255;
		return t[7:0];
	endfunction

	function automatic logic [7:0] rotate(input logic [7:0] h, input logic [7:0] a);
		logic signed [9:0] t;
		t = $signed({2'b00, h}) + $signed({{2{a[7]}}, a});
		if (t < 0) t = t + 10'sd255;
		else if (t > 10'sd255) t = t - 10'sd255;
		return t[7:0];
	endfunction

	assign adv      = !(vld_s[15] && out_stall);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[14:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s[1] <= '{op: operation, amt: amount, r: red, g: green, b: blue,
				h: hue_in, l: lum_in, s: sat_in};
			for (int i = 2; i <= 6; i++) ctl_s[i] <= ctl_s[i-1];
			res_s[7] <= adj;
			for (int i = 8; i <= 14; i++) res_s[i] <= res_s[i-1];
		end
	end

	rhpa_to_hls u_to_hls (
		.clk(clk), .adv(adv), .red(red), .green(green), .blue(blue),
		.hue(hls_hue), .lum(hls_lum), .sat(hls_sat)
	);

	always_comb begin
		adj.pass = 1'b0;
		adj.r    = ctl_s[6].r;
		adj.g    = ctl_s[6].g;
		adj.b    = ctl_s[6].b;
		adj.h    = hls_hue;
		adj.l    = hls_lum;
		adj.s    = hls_sat;
		case (rhpa_pkg::op_t'(ctl_s[6].op))
			rhpa_pkg::OP_FROM_HLS: begin
				adj.h = ctl_s[6].h;
				adj.l = ctl_s[6].l;
				adj.s = ctl_s[6].s;
			end
			rhpa_pkg::OP_ROTATE_HUE: adj.h = rotate(hls_hue, ctl_s[6].amt);
			rhpa_pkg::OP_INC_SAT:    adj.s = clamp_step(hls_sat, ctl_s[6].amt, 1'b0);
			rhpa_pkg::OP_DEC_SAT:    adj.s = clamp_step(hls_sat, ctl_s[6].amt, 1'b1);
			rhpa_pkg::OP_INC_LUM:    adj.l = clamp_step(hls_lum, ctl_s[6].amt, 1'b0);
			rhpa_pkg::OP_DEC_LUM:    adj.l = clamp_step(hls_lum, ctl_s[6].amt, 1'b1);
			default:                 adj.pass = 1'b1;
		endcase
	end

	rhpa_to_rgb u_to_rgb (
		.clk(clk), .adv(adv), .hue(res_s[7].h), .lum(res_s[7].l), .sat(res_s[7].s),
		.red(rgb_r), .green(rgb_g), .blue(rgb_b)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			out_pass_q <= res_s[14].pass;
			red_q      <= res_s[14].pass ? res_s[14].r : rgb_r;
			green_q    <= res_s[14].pass ? res_s[14].g : rgb_g;
			blue_q     <= res_s[14].pass ? res_s[14].b : rgb_b;
			hue_q      <= res_s[14].h;
			lum_q      <= res_s[14].l;
			sat_q      <= res_s[14].s;
		end
	end

	assign out_valid = vld_s[15];
	assign red_out   = red_q;
	assign green_out = green_q;
	assign blue_out  = blue_q;
	assign hue_out   = hue_q;
	assign lum_out   = lum_q;
	assign sat_out   = sat_q;

	a_entry: assert property (@(posedge clk) disable iff (!arst_n)
		$past(adv) |-> vld_s[1] == $past(in_valid))
		else $error("entry valid bit does not follow the accepted item");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s))
		else $error("valid bits moved while the pipeline was held");

	a_grey: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_pass_q && red_out == green_out && green_out == blue_out
		|-> sat_out == 8'd0 && hue_out == 8'd0 && lum_out == red_out)
		else $error("grey pixel gave non-zero hue or saturation");

	a_flat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_pass_q && sat_out == 8'd0
		|-> red_out == lum_out && green_out == lum_out && blue_out == lum_out)
		else $error("zero saturation did not give a grey pixel");
endmodule
